/* hw/rtl/pid_pkg.sv */
`timescale 1ns / 1ps

package pid_pkg;

    // Mnemonic codes, alphabetical; CCS covers the set/clear condition code group
    typedef enum logic [5:0] {
        MN_ILLEGAL = 6'd0,
        MN_ADC, MN_ADD, MN_ASH, MN_ASHC, MN_ASL, MN_ASR, MN_BCC, MN_BCS,
        MN_BEQ, MN_BGE, MN_BGT, MN_BHI, MN_BIC, MN_BIS, MN_BIT, MN_BLE,
        MN_BLOS, MN_BLT, MN_BMI, MN_BNE, MN_BPL, MN_BPT, MN_BR, MN_BVC,
        MN_BVS, MN_CCS, MN_CLR, MN_CMP, MN_COM, MN_DEC, MN_DIV, MN_EMT,
        MN_HALT, MN_INC, MN_IOT, MN_JMP, MN_JSR, MN_MARK, MN_MFPI, MN_MFPS,
        MN_MOV, MN_MTPI, MN_MTPS, MN_MUL, MN_NEG, MN_RESET, MN_ROL, MN_ROR,
        MN_RTI, MN_RTS, MN_RTT, MN_SBC, MN_SEXT, MN_SOB, MN_SUB, MN_SWAB,
        MN_TRAP, MN_TST, MN_WAIT, MN_XOR
    } mn_t;

    // Operand formats
    typedef enum logic [2:0] {
        FMT_NONE   = 3'd0,
        FMT_SINGLE = 3'd1,
        FMT_DOUBLE = 3'd2,
        FMT_REGOP  = 3'd3,
        FMT_BRANCH = 3'd4,
        FMT_REG    = 3'd5,
        FMT_LIT    = 3'd6
    } fmt_t;

    // Opcode match patterns
    localparam logic [15:0] RTS_MASK = 16'o177770;
    localparam logic [15:0] RTS_CODE = 16'o000200;
    localparam logic [15:0] CCS_MASK = 16'o177740;
    localparam logic [15:0] CCS_CODE = 16'o000240;
    localparam logic [15:0] EMT_MASK = 16'o177400;
    localparam logic [15:0] EMT_CODE = 16'o104000;

    // Decoded result; first member sits in the highest bits, so word_count lands at bit 0
    typedef struct packed {
        logic [7:0] literal_field;
        logic [2:0] dst_reg;
        logic [2:0] dst_mode;
        logic [2:0] src_reg;
        logic [2:0] src_mode;
        logic [2:0] operand_format;
        logic       byte_op;
        logic [5:0] mnemonic;
        logic [1:0] word_count;
    } pid_result_t;

    // One extra word for immediate/absolute (mode 2/3 on PC) and indexed modes
    function automatic logic extra_word(input logic [5:0] modereg);
        logic [2:0] mode;
        logic [2:0] rn;
        mode = modereg[5:3];
        rn   = modereg[2:0];
        return (mode[2] && mode[1]) || ((mode == 3'd2 || mode == 3'd3) && rn == 3'd7);
    endfunction

    // Single-operand group, opcodes 0050..0063
    function automatic mn_t single_mn(input logic [3:0] idx);
        mn_t r;
        case (idx)
            4'd0:    r = MN_CLR;
            4'd1:    r = MN_COM;
            4'd2:    r = MN_INC;
            4'd3:    r = MN_DEC;
            4'd4:    r = MN_NEG;
            4'd5:    r = MN_ADC;
            4'd6:    r = MN_SBC;
            4'd7:    r = MN_TST;
            4'd8:    r = MN_ROR;
            4'd9:    r = MN_ROL;
            4'd10:   r = MN_ASR;
            4'd11:   r = MN_ASL;
            default: r = MN_ILLEGAL;
        endcase
        return r;
    endfunction

    // Branch group, indexed by bit 15 and bits 10..8
    function automatic mn_t branch_mn(input logic [3:0] idx);
        mn_t r;
        case (idx)
            4'd1:    r = MN_BR;
            4'd2:    r = MN_BNE;
            4'd3:    r = MN_BEQ;
            4'd4:    r = MN_BGE;
            4'd5:    r = MN_BLT;
            4'd6:    r = MN_BGT;
            4'd7:    r = MN_BLE;
            4'd8:    r = MN_BPL;
            4'd9:    r = MN_BMI;
            4'd10:   r = MN_BHI;
            4'd11:   r = MN_BLOS;
            4'd12:   r = MN_BVC;
            4'd13:   r = MN_BVS;
            4'd14:   r = MN_BCC;
            4'd15:   r = MN_BCS;
            default: r = MN_ILLEGAL;
        endcase
        return r;
    endfunction

    // Zero-operand group, words 0..6
    function automatic mn_t misc_mn(input logic [2:0] idx);
        mn_t r;
        case (idx)
            3'd0:    r = MN_HALT;
            3'd1:    r = MN_WAIT;
            3'd2:    r = MN_RTI;
            3'd3:    r = MN_BPT;
            3'd4:    r = MN_IOT;
            3'd5:    r = MN_RESET;
            3'd6:    r = MN_RTT;
            default: r = MN_ILLEGAL;
        endcase
        return r;
    endfunction

    // Double-operand group, indexed by bits 14..12
    function automatic mn_t double_mn(input logic [2:0] idx);
        mn_t r;
        case (idx)
            3'd1:    r = MN_MOV;
            3'd2:    r = MN_CMP;
            3'd3:    r = MN_BIT;
            3'd4:    r = MN_BIC;
            3'd5:    r = MN_BIS;
            default: r = MN_ILLEGAL;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/pdp11_instruction_decoder.sv */
`timescale 1ns / 1ps

// PDP-11 instruction decoder. Takes one 16-bit instruction word per clock, unless stalled,
// and returns the mnemonic index, byte flag, operand format, mode/register fields, literal
// field and instruction length in words (0 for an illegal word). The block takes one beat
// per cycle while s_tready is high; a word is registered, decoded in one combinational pass
// and registered again before it appears on m_tdata. Both stages hold under backpressure,
// and s_tready follows m_tready combinationally when both stages are full.
module pdp11_instruction_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] instruction_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] word_count, [7:2] mnemonic, [8] byte_op,
                                   // [11:9] operand_format, [14:12] src_mode,
                                   // [17:15] src_reg, [20:18] dst_mode, [23:21] dst_reg,
                                   // [31:24] literal_field
);
    import pid_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] in_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    pid_result_t out_result_reg;
    pid_result_t decoded;
    logic        out_advance;

    // Advance the output stage when empty or drained this cycle
    assign out_advance    = !out_valid_reg || m_tready;
    assign s_tready       = !in_valid_reg || out_advance;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_advance ? in_valid_reg : out_valid_reg;

    pid_decode u_decode (
        .word   (in_word_reg),
        .result (decoded)
    );

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat and the decoded result; hold while stalled
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= s_tdata;
        end
        if (out_advance && in_valid_reg) begin
            out_result_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;

endmodule

/* hw/rtl/pid_decode.sv */
`timescale 1ns / 1ps

module pid_decode (
    input  logic [15:0]         word,
    output pid_pkg::pid_result_t result
);
    import pid_pkg::*;

    logic       b15;
    logic [2:0] top;
    logic [5:0] mid;

    assign b15 = word[15];
    assign top = word[14:12];
    assign mid = word[11:6];

    // Classify the word and build the result
    always_comb begin
        mn_t        mn;
        fmt_t       fmt;
        logic       byteop;
        logic [7:0] lit;
        logic [3:0] sidx;
        logic [3:0] bidx;
        logic [1:0] words;

        mn     = MN_ILLEGAL;
        fmt    = FMT_NONE;
        byteop = 1'b0;
        lit    = 8'd0;
        sidx   = 4'(mid - 6'o50);
        bidx   = {b15, word[10:8]};

        if (top == 3'd0) begin
            if (mid == 6'o01 && !b15) begin
                mn  = MN_JMP;
                fmt = FMT_SINGLE;
            end else if (mid == 6'o02 && (word & RTS_MASK) == RTS_CODE) begin
                mn  = MN_RTS;
                fmt = FMT_REG;
            end else if (mid == 6'o02 && (word & CCS_MASK) == CCS_CODE) begin
                mn  = MN_CCS;
                fmt = FMT_LIT;
                lit = {3'd0, word[4:0]};
            end else if (mid == 6'o03 && !b15) begin
                mn  = MN_SWAB;
                fmt = FMT_SINGLE;
            end else if (mid[5:3] == 3'o4) begin
                if (!b15) begin
                    mn  = MN_JSR;
                    fmt = FMT_REGOP;
                end else begin
                    mn  = ((word & EMT_MASK) == EMT_CODE) ? MN_EMT : MN_TRAP;
                    fmt = FMT_LIT;
                    lit = word[7:0];
                end
            end else if (mid >= 6'o50 && mid <= 6'o63) begin
                mn     = single_mn(sidx);
                fmt    = FMT_SINGLE;
                byteop = b15;
            end else if (mid == 6'o64) begin
                if (b15) begin
                    mn     = MN_MTPS;
                    fmt    = FMT_SINGLE;
                    byteop = 1'b1;
                end else begin
                    mn  = MN_MARK;
                    fmt = FMT_LIT;
                    lit = {2'd0, word[5:0]};
                end
            end else if (mid == 6'o65) begin
                mn  = MN_MFPI;
                fmt = FMT_SINGLE;
            end else if (mid == 6'o66) begin
                mn  = MN_MTPI;
                fmt = FMT_SINGLE;
            end else if (mid == 6'o67) begin
                mn     = b15 ? MN_MFPS : MN_SEXT;
                byteop = b15;
                fmt    = FMT_SINGLE;
            end else if (!word[11]) begin
                if (bidx != 4'd0) begin
                    mn  = branch_mn(bidx);
                    fmt = FMT_BRANCH;
                    lit = word[7:0];
                end else if (word <= 16'd6) begin
                    mn  = misc_mn(word[2:0]);
                    fmt = FMT_NONE;
                end
            end
        end else if (top <= 3'd5) begin
            mn     = double_mn(top);
            fmt    = FMT_DOUBLE;
            byteop = b15;
        end else if (top == 3'd6) begin
            mn  = b15 ? MN_SUB : MN_ADD;
            fmt = FMT_DOUBLE;
        end else if (!b15) begin
            case (word[11:9])
                3'd0: begin
                    mn  = MN_MUL;
                    fmt = FMT_REGOP;
                end
                3'd1: begin
                    mn  = MN_DIV;
                    fmt = FMT_REGOP;
                end
                3'd2: begin
                    mn  = MN_ASH;
                    fmt = FMT_REGOP;
                end
                3'd3: begin
                    mn  = MN_ASHC;
                    fmt = FMT_REGOP;
                end
                3'd4: begin
                    mn  = MN_XOR;
                    fmt = FMT_REGOP;
                end
                3'd7: begin
                    mn  = MN_SOB;
                    fmt = FMT_LIT;
                    lit = {2'd0, word[5:0]};
                end
                default: begin
                    mn  = MN_ILLEGAL;
                    fmt = FMT_NONE;
                end
            endcase
        end

        // Count extension words per general operand
        words = 2'd1;
        if (fmt == FMT_DOUBLE) begin
            words = 2'd1 + {1'b0, extra_word(word[11:6])} + {1'b0, extra_word(word[5:0])};
        end else if (fmt == FMT_SINGLE || fmt == FMT_REGOP) begin
            words = 2'd1 + {1'b0, extra_word(word[5:0])};
        end

        // Zero every field of an illegal word
        if (mn == MN_ILLEGAL) begin
            result = '0;
        end else begin
            result.word_count     = words;
            result.mnemonic       = mn;
            result.byte_op        = byteop;
            result.operand_format = fmt;
            result.src_mode       = word[11:9];
            result.src_reg        = word[8:6];
            result.dst_mode       = word[5:3];
            result.dst_reg        = word[2:0];
            result.literal_field  = lit;
        end
    end

endmodule
